### src/rotor_cipher_machine_defines.svh
// Assertion macros shared by the rotor cipher machine RTL.
// Simulation builds get the checks; synthesis builds see empty bodies.
`ifndef ROTOR_CIPHER_MACHINE_DEFINES_SVH
`define ROTOR_CIPHER_MACHINE_DEFINES_SVH

`ifndef SYNTHESIS

`define RCM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotor cipher machine: same-cycle check failed");

`define RCM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotor cipher machine: next-cycle check failed");

`else

`define RCM_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define RCM_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

### src/rcm_pkg.sv
// Shared types and constants for the rotor cipher machine.
// No dependencies; used by the top level and the mapping table memory.
package rcm_pkg;

    localparam int ACTION_W = 2;
    localparam int LETTER_W = 8;
    localparam int SEL_W    = 4;
    localparam int IDX_W    = 5;
    localparam int CFG_W    = 3;

    localparam logic [LETTER_W-1:0] ASCII_A = 8'd65;
    localparam logic [LETTER_W-1:0] ASCII_Z = 8'd90;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENCODE = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_SETPOS = 2'd2,
        ACT_NONE   = 2'd3
    } rcm_action_t;

    typedef enum logic [7:0] {
        ST_IDLE        = 8'b0000_0001,
        ST_DECODE      = 8'b0000_0010,
        ST_NOTCH_MID   = 8'b0000_0100,
        ST_NOTCH_RIGHT = 8'b0000_1000,
        ST_STEP        = 8'b0001_0000,
        ST_ROUTE       = 8'b0010_0000,
        ST_FINISH      = 8'b0100_0000,
        ST_DONE        = 8'b1000_0000
    } rcm_state_t;

endpackage

### src/rcm_map_mem.sv
// Mapping table memory: rotor wiring both ways, reflector and plugboard.
// One write port, one read port with registered read data; uses rcm_pkg.
module rcm_map_mem #(
    parameter int DEPTH  = 260,
    parameter int ADDR_W = 9
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [rcm_pkg::IDX_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [rcm_pkg::IDX_W-1:0] rdata
);
    import rcm_pkg::*;

    logic [IDX_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/rcm_notch_mem.sv
// Notch flag memory, one bit per rotor and letter, with per-entry valid bits
// so that every flag reads as cleared after reset. No package dependencies.
module rcm_notch_mem #(
    parameter int DEPTH  = 104,
    parameter int ADDR_W = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic              wbit,
    input  logic [ADDR_W-1:0] raddr,
    output logic              rflag
);

    logic             mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic             rflag_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wbit;
        end
        rflag_reg <= mem[raddr] & valid_reg[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    assign rflag = rflag_reg;

endmodule

### src/rotor_cipher_machine.sv
// Rotor cipher machine top level: handshakes, sequencer and rotor positions.
// Depends on rcm_pkg, rcm_map_mem, rcm_notch_mem and the assertion macros.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid/s_ready, s_action .. s_entry_*  | in
//  result  | m_valid/m_ready, m_cipher_letter .. pos | out
//  config  | cfg_valid/cfg_ready, cfg_wdata          | in
//
// A table write, position set or bad letter goes from decode straight to the final
// state, which loads the result register; a good letter first passes decode and the
// notch lookups, then 2*n+3 dependent mapping-memory reads (n active rotors), one per
// cycle on the single read port, then a finish state. The sequencer then returns to
// idle to take the next word. Reset clears positions, notch flags and plugboard.
// A word waiting on m_ready stalls only the sequencer's final state.
`include "rotor_cipher_machine_defines.svh"
module rotor_cipher_machine #(
    parameter int MAX_ROTORS = 4,
    parameter int ALPHABET   = 26
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rcm_pkg::ACTION_W-1:0] s_action,
    input  logic [rcm_pkg::LETTER_W-1:0] s_letter,
    input  logic [rcm_pkg::SEL_W-1:0]    s_table_select,
    input  logic [rcm_pkg::IDX_W-1:0]    s_entry_position,
    input  logic [rcm_pkg::IDX_W-1:0]    s_entry_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rcm_pkg::LETTER_W-1:0] m_cipher_letter,
    output logic                         m_bad_letter,
    output logic [rcm_pkg::IDX_W-1:0]    m_right_position,
    output logic [rcm_pkg::IDX_W-1:0]    m_middle_position,
    output logic [rcm_pkg::IDX_W-1:0]    m_left_position,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rcm_pkg::CFG_W-1:0]    cfg_wdata
);
    import rcm_pkg::*;

    localparam int ROT_W       = $clog2(MAX_ROTORS);
    localparam int RN_W        = $clog2(MAX_ROTORS + 1);
    localparam int STG_W       = $clog2(2 * MAX_ROTORS + 3);
    localparam int PV_W        = $clog2(ALPHABET);
    localparam int MAP_DEPTH   = (2 * MAX_ROTORS + 2) * ALPHABET;
    localparam int MAP_AW      = $clog2(MAP_DEPTH);
    localparam int NOTCH_DEPTH = MAX_ROTORS * ALPHABET;
    localparam int NOTCH_AW    = $clog2(NOTCH_DEPTH);
    localparam int REFL_TBL    = 2 * MAX_ROTORS;
    localparam int PLUG_TBL    = 2 * MAX_ROTORS + 1;
    localparam int NOTCH_SEL   = 2 * MAX_ROTORS + 2;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ALPHABET - 1);

    function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (int'(s) >= ALPHABET) begin
            s = s - (IDX_W + 1)'(ALPHABET);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] sub_mod(input logic [IDX_W-1:0] d,
                                                 input logic [IDX_W-1:0] off);
        logic [IDX_W:0] s;
        if (d >= off) begin
            s = {1'b0, d} - {1'b0, off};
        end else begin
            s = {1'b0, d} + (IDX_W + 1)'(ALPHABET) - {1'b0, off};
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] inc_pos(input logic [IDX_W-1:0] p);
        return (p == IDX_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [MAP_AW-1:0] map_addr(input int tbl,
                                                   input logic [IDX_W-1:0] y);
        return MAP_AW'(tbl * ALPHABET + int'(y));
    endfunction

    // Latched input word and configuration.
    rcm_state_t        state_reg, state_next;
    rcm_action_t       act_reg;
    logic [LETTER_W-1:0] letter_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [IDX_W-1:0]  epos_reg;
    logic [IDX_W-1:0]  eval_reg;
    logic [CFG_W-1:0]  rotors_reg;

    logic [IDX_W-1:0]  pos_reg [MAX_ROTORS];
    logic [ALPHABET-1:0] plug_valid_reg;
    logic              notch_mid_reg;
    logic [STG_W-1:0]  stage_reg;
    logic [IDX_W-1:0]  prev_off_reg;
    logic [IDX_W-1:0]  prev_y_reg;
    logic              prev_ident_reg;
    logic [LETTER_W-1:0] res_cipher_reg;
    logic              res_bad_reg;

    logic              m_valid_reg;
    logic [LETTER_W-1:0] m_cipher_letter_reg;
    logic              m_bad_letter_reg;
    logic [IDX_W-1:0]  m_right_position_reg;
    logic [IDX_W-1:0]  m_middle_position_reg;
    logic [IDX_W-1:0]  m_left_position_reg;

    logic [RN_W-1:0]   n_act;
    logic [STG_W-1:0]  last_stage;
    logic              letter_bad;
    logic [IDX_W-1:0]  letter_idx;
    logic              setpos_ok;

    int                tbl_cur;
    logic [ROT_W-1:0]  rot_cur;
    logic              use_off;
    logic [IDX_W-1:0]  off_cur;
    logic [IDX_W-1:0]  post_x;
    logic [IDX_W-1:0]  issue_x;
    logic [IDX_W-1:0]  issue_y;
    logic              is_plug;

    logic              map_we;
    logic [MAP_AW-1:0] map_waddr;
    logic [MAP_AW-1:0] map_raddr;
    logic [IDX_W-1:0]  map_rdata;
    logic              notch_we;
    logic [NOTCH_AW-1:0] notch_waddr;
    logic [NOTCH_AW-1:0] notch_raddr;
    logic              notch_rflag;
    logic              plug_set;
    logic              out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        if (int'(rotors_reg) < 3) begin
            n_act = RN_W'(3);
        end else if (int'(rotors_reg) > MAX_ROTORS) begin
            n_act = RN_W'(MAX_ROTORS);
        end else begin
            n_act = RN_W'(rotors_reg);
        end
    end

    assign last_stage = STG_W'(2 * int'(n_act) + 2);
    assign letter_bad = (letter_reg < ASCII_A) || (letter_reg > ASCII_Z)
                        || (int'(letter_reg - ASCII_A) >= ALPHABET);
    assign letter_idx = IDX_W'(letter_reg - ASCII_A);
    assign setpos_ok  = (int'(sel_reg) < int'(n_act)) && (int'(eval_reg) < ALPHABET);

    // Lookup chain: plugboard, rotors forward, reflector, rotors back, plugboard.
    always_comb begin
        int k;
        int nn;
        k = int'(stage_reg);
        nn = int'(n_act);
        rot_cur = '0;
        use_off = 1'b0;
        if (k == 0 || k == 2 * nn + 2) begin
            tbl_cur = PLUG_TBL;
        end else if (k <= nn) begin
            tbl_cur = k - 1;
            rot_cur = ROT_W'(k - 1);
            use_off = 1'b1;
        end else if (k == nn + 1) begin
            tbl_cur = REFL_TBL;
        end else begin
            tbl_cur = MAX_ROTORS + 2 * nn + 1 - k;
            rot_cur = ROT_W'(2 * nn + 1 - k);
            use_off = 1'b1;
        end
    end

    assign off_cur = use_off ? pos_reg[rot_cur] : '0;
    // An unwritten plugboard entry maps a letter to itself.
    assign post_x  = prev_ident_reg ? prev_y_reg : sub_mod(map_rdata, prev_off_reg);
    assign issue_x = (state_reg == ST_STEP) ? letter_idx : post_x;
    assign issue_y = add_mod(issue_x, off_cur);
    assign is_plug = (tbl_cur == PLUG_TBL);

    always_comb begin
        case (state_reg)
            ST_DECODE:         map_raddr = map_addr(1, pos_reg[1]);
            ST_NOTCH_MID:      map_raddr = map_addr(0, pos_reg[0]);
            ST_STEP, ST_ROUTE: map_raddr = map_addr(tbl_cur, issue_y);
            default:           map_raddr = '0;
        endcase
    end

    always_comb begin
        case (state_reg)
            ST_NOTCH_MID:   notch_raddr = NOTCH_AW'(ALPHABET + int'(map_rdata));
            ST_NOTCH_RIGHT: notch_raddr = NOTCH_AW'(int'(map_rdata));
            default:        notch_raddr = '0;
        endcase
    end

    // Table writes are decoded once the word has been latched.
    always_comb begin
        int  sel_i;
        logic pos_ok;
        logic val_ok;
        sel_i    = int'(sel_reg);
        pos_ok   = int'(epos_reg) < ALPHABET;
        val_ok   = int'(eval_reg) < ALPHABET;
        map_we   = 1'b0;
        notch_we = 1'b0;
        plug_set = 1'b0;
        if (state_reg == ST_DECODE && act_reg == ACT_WRITE && pos_ok) begin
            if (sel_i <= PLUG_TBL) begin
                map_we   = val_ok;
                plug_set = val_ok && (sel_i == PLUG_TBL);
            end else if (sel_i < NOTCH_SEL + MAX_ROTORS) begin
                notch_we = 1'b1;
            end
        end
        map_waddr   = map_addr(sel_i, epos_reg);
        notch_waddr = NOTCH_AW'((sel_i - NOTCH_SEL) * ALPHABET + int'(epos_reg));
    end

    rcm_map_mem #(
        .DEPTH  (MAP_DEPTH),
        .ADDR_W (MAP_AW)
    ) u_map_mem (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (eval_reg),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    rcm_notch_mem #(
        .DEPTH  (NOTCH_DEPTH),
        .ADDR_W (NOTCH_AW)
    ) u_notch_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (notch_we),
        .waddr   (notch_waddr),
        .wbit    (eval_reg[0]),
        .raddr   (notch_raddr),
        .rflag   (notch_rflag)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (act_reg == ACT_ENCODE && !letter_bad) begin
                    state_next = ST_NOTCH_MID;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_NOTCH_MID:   state_next = ST_NOTCH_RIGHT;
            ST_NOTCH_RIGHT: state_next = ST_STEP;
            ST_STEP:        state_next = ST_ROUTE;
            ST_ROUTE: begin
                if (stage_reg == last_stage) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:      state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rotors_reg     <= CFG_W'(3);
            plug_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
            for (int r = 0; r < MAX_ROTORS; r++) begin
                pos_reg[r] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                rotors_reg <= cfg_wdata;
            end
            // The final state reloads the result register itself.
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        act_reg    <= rcm_action_t'(s_action);
                        letter_reg <= s_letter;
                        sel_reg    <= s_table_select;
                        epos_reg   <= s_entry_position;
                        eval_reg   <= s_entry_value;
                    end
                end
                ST_DECODE: begin
                    res_cipher_reg <= '0;
                    res_bad_reg    <= (act_reg == ACT_ENCODE) && letter_bad;
                    stage_reg      <= '0;
                    if (act_reg == ACT_SETPOS && setpos_ok) begin
                        pos_reg[sel_reg[ROT_W-1:0]] <= eval_reg;
                    end
                    if (plug_set) begin
                        plug_valid_reg[epos_reg[PV_W-1:0]] <= 1'b1;
                    end
                end
                ST_NOTCH_RIGHT: begin
                    notch_mid_reg <= notch_rflag;
                end
                ST_STEP: begin
                    // The middle rotor at its notch double-steps itself and the left one.
                    if (notch_mid_reg) begin
                        pos_reg[1] <= inc_pos(pos_reg[1]);
                        pos_reg[2] <= inc_pos(pos_reg[2]);
                    end else if (notch_rflag) begin
                        pos_reg[1] <= inc_pos(pos_reg[1]);
                    end
                    pos_reg[0]     <= inc_pos(pos_reg[0]);
                    stage_reg      <= STG_W'(1);
                    prev_off_reg   <= off_cur;
                    prev_y_reg     <= issue_y;
                    prev_ident_reg <= is_plug && !plug_valid_reg[issue_y[PV_W-1:0]];
                end
                ST_ROUTE: begin
                    stage_reg      <= stage_reg + 1'b1;
                    prev_off_reg   <= off_cur;
                    prev_y_reg     <= issue_y;
                    prev_ident_reg <= is_plug && !plug_valid_reg[issue_y[PV_W-1:0]];
                end
                ST_FINISH: begin
                    res_cipher_reg <= LETTER_W'(post_x) + ASCII_A;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg           <= 1'b1;
                        m_cipher_letter_reg   <= res_cipher_reg;
                        m_bad_letter_reg      <= res_bad_reg;
                        m_right_position_reg  <= pos_reg[0];
                        m_middle_position_reg <= pos_reg[1];
                        m_left_position_reg   <= pos_reg[2];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cipher_letter   = m_cipher_letter_reg;
    assign m_bad_letter      = m_bad_letter_reg;
    assign m_right_position  = m_right_position_reg;
    assign m_middle_position = m_middle_position_reg;
    assign m_left_position   = m_left_position_reg;

    `RCM_ASSERT_IMP(a_bad_word_no_letter, aclk, aresetn, m_valid_reg && m_bad_letter_reg, m_cipher_letter_reg == '0)
    `RCM_ASSERT_IMP(a_stage_bound, aclk, aresetn, state_reg == ST_ROUTE, (stage_reg != '0) && (stage_reg <= last_stage))
    `RCM_ASSERT_NXT(a_right_steps, aclk, aresetn, state_reg == ST_STEP, pos_reg[0] == inc_pos($past(pos_reg[0])))
    `RCM_ASSERT_IMP(a_positions_in_range, aclk, aresetn, m_valid_reg, (int'(m_right_position_reg) < ALPHABET) && (int'(m_middle_position_reg) < ALPHABET) && (int'(m_left_position_reg) < ALPHABET))

endmodule
